// ----- hdl/page_frame_replacement_unit_core_macros.svh -----
// Assertion macros for the checker file of the page frame replacement unit.
// No dependencies; included by bare file name.
`ifndef PAGE_FRAME_REPLACEMENT_UNIT_CORE_MACROS_SVH
`define PAGE_FRAME_REPLACEMENT_UNIT_CORE_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define PFRU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PFRU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/pfru_pkg.sv -----
// Shared types and constants for the page frame replacement unit.
// No dependencies; imported by the core and its checker.
`default_nettype none

package pfru_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 2'd1;

  // Field widths fixed by the interface
  localparam int COUNT_W = 4;
  localparam int FAULT_W = 32;

  localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 4'd8;

  typedef enum logic {
    POLICY_FIFO = 1'b0,
    POLICY_LRU  = 1'b1
  } policy_t;

endpackage

`default_nettype wire

// ----- hdl/page_frame_replacement_unit_core.sv -----
// Page frame replacement unit: fully associative frame lookup with FIFO or LRU victim choice.
// Depends on pfru_pkg.
//
// Usage: one page reference is taken per cycle unless a stalled result holds the input
// register (in_stall). In the input register all frames are compared in parallel and the
// victim is chosen; the result is loaded into the output register when the input stage
// advances, and a new item can enter as the last one moves on. The rate is set by the
// lookup and age update in the input stage, which sees the state left by the
// item just before it. Load and use order are kept as two pairwise age matrices (bit
// [i][j] set when frame i is older than frame j) rather than step stamps, so the victim is
// the active frame older than every other active frame. Configuration writes are taken at
// any time (cfg_ready is always high) but are meant to happen only while the unit is idle.
// Reset clears the valid bits and the fault count at once; no clearing pass is needed.
`default_nettype none

module page_frame_replacement_unit_core
  import pfru_pkg::*;
#(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [PAGE_BITS-1:0]  in_page,
  // result channel
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic                  out_hit,
  output      logic [$clog2((FRAMES > 1) ? FRAMES : 2)-1:0] out_frame,
  output      logic                  out_evicted_valid,
  output      logic [PAGE_BITS-1:0]  out_evicted_page,
  output      logic [FAULT_W-1:0]    out_fault_count,
  // configuration channel
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2((FRAMES > 1) ? FRAMES : 2);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // configuration registers
  logic [COUNT_W-1:0] frame_count_r;
  policy_t            policy_r;

  // input stage
  logic                 s1_valid_r;
  logic [PAGE_BITS-1:0] s1_page_r;

  // frame state
  logic [FRAMES-1:0]    valid_r;
  logic [PAGE_BITS-1:0] page_r     [FRAMES];
  logic [FRAMES-1:0]    load_old_r [FRAMES];
  logic [FRAMES-1:0]    use_old_r  [FRAMES];
  logic [FAULT_W-1:0]   faults_r;
  logic [FAULT_W-1:0]   faults_nxt;

  // output register
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [IDX_W-1:0]     out_frame_r;
  logic                 out_evicted_valid_r;
  logic [PAGE_BITS-1:0] out_evicted_page_r;
  logic [FAULT_W-1:0]   out_fault_count_r;

  // lookup results
  logic              advance;
  logic              step;
  logic [FRAMES-1:0] active;
  logic [FRAMES-1:0] oldest;
  logic              hit;
  logic [IDX_W-1:0]  match_idx;
  logic              empty_found;
  logic [IDX_W-1:0]  empty_idx;
  logic [IDX_W-1:0]  victim_idx;
  logic              evict;
  logic [IDX_W-1:0]  tgt_idx;
  logic [PAGE_BITS-1:0] evicted_page;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RESET;
      policy_r      <= POLICY_FIFO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_COUNT: frame_count_r <= cfg_wdata[COUNT_W-1:0];
        REG_POLICY:      policy_r      <= policy_t'(cfg_wdata[0]);
        default:         ;
      endcase
    end
  end

  // handshake: the input stage moves on when the output register is free
  assign advance  = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  // load the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_page_r <= in_page;
    end
  end

  // active frames: a count of zero acts as one, a count above FRAMES as FRAMES
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = (i == 0) || (CMP_W'(i) < CMP_W'(frame_count_r));
    end
  end

  // lowest matching frame and lowest empty frame
  always_comb begin
    hit         = 1'b0;
    match_idx   = '0;
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (active[i] && valid_r[i] && !hit && (page_r[i] == s1_page_r)) begin
        hit       = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (active[i] && !valid_r[i] && !empty_found) begin
        empty_found = 1'b1;
        empty_idx   = IDX_W'(i);
      end
    end
  end

  // flag the active frame that is older than every other active frame
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      oldest[i] = active[i];
      for (int j = 0; j < FRAMES; j++) begin
        if ((j != i) && active[j]) begin
          if (policy_r == POLICY_LRU) begin
            if (!use_old_r[i][j]) oldest[i] = 1'b0;
          end else begin
            if (!load_old_r[i][j]) oldest[i] = 1'b0;
          end
        end
      end
    end
  end

  // pick the lowest flagged frame as victim
  always_comb begin
    victim_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (oldest[i]) victim_idx = IDX_W'(i);
    end
  end

  assign evict        = !hit && !empty_found;
  assign tgt_idx      = hit ? match_idx : (empty_found ? empty_idx : victim_idx);
  assign evicted_page = evict ? page_r[victim_idx] : '0;
  assign faults_nxt   = hit ? faults_r : faults_r + FAULT_W'(1);

  // update valid bits and fault count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      faults_r <= '0;
    end else if (step) begin
      faults_r <= faults_nxt;
      if (!hit) valid_r[tgt_idx] <= 1'b1;
    end
  end

  // update pages and age order: the target becomes the most recently used frame, and on a miss also the newest loaded
  always_ff @(posedge clk) begin
    if (step) begin
      if (!hit) page_r[tgt_idx] <= s1_page_r;
      for (int i = 0; i < FRAMES; i++) begin
        for (int j = 0; j < FRAMES; j++) begin
          if ((IDX_W'(i) == tgt_idx) && (IDX_W'(j) != tgt_idx)) begin
            use_old_r[i][j] <= 1'b0;
            if (!hit) load_old_r[i][j] <= 1'b0;
          end else if ((IDX_W'(j) == tgt_idx) && (IDX_W'(i) != tgt_idx)) begin
            use_old_r[i][j] <= 1'b1;
            if (!hit) load_old_r[i][j] <= 1'b1;
          end
        end
      end
    end
  end

  // output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_hit_r           <= hit;
      out_frame_r         <= tgt_idx;
      out_evicted_valid_r <= evict;
      out_evicted_page_r  <= evicted_page;
      out_fault_count_r   <= faults_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame         = out_frame_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_fault_count   = out_fault_count_r;

endmodule

`default_nettype wire

// ----- hdl/pfru_checker.sv -----
// Port-level checks for the page frame replacement unit, bound to its top level.
// Depends on pfru_pkg and page_frame_replacement_unit_core_macros.svh.
`default_nettype none
`include "page_frame_replacement_unit_core_macros.svh"

module pfru_checker
  import pfru_pkg::*;
#(
  parameter int PAGE_BITS = 16
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic                 out_hit,
  input wire logic                 out_evicted_valid,
  input wire logic [PAGE_BITS-1:0] out_evicted_page,
  input wire logic [FAULT_W-1:0]   out_fault_count
);

  // a stalled result stays and keeps its fault count
  `PFRU_ASSERT(a_stall_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_fault_count), "stalled result changed")

  // a hit never evicts
  `PFRU_ASSERT(a_hit_no_evict, clk, rst_n, out_valid && out_hit |-> !out_evicted_valid, "hit reported an eviction")

  // no eviction means a zero evicted page
  `PFRU_ASSERT(a_evict_page_zero, clk, rst_n, out_valid && !out_evicted_valid |-> out_evicted_page == '0, "evicted page not zero")

  // reset empties the output register
  `PFRU_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind page_frame_replacement_unit_core pfru_checker #(
  .PAGE_BITS(PAGE_BITS)
) u_pfru_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_hit           (out_hit),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_page  (out_evicted_page),
  .out_fault_count   (out_fault_count)
);

`default_nettype wire

// ----- sim/tb_page_frame_replacement_unit_core.sv -----
// Self-checking testbench for page_frame_replacement_unit_core (FIFO and LRU page frames).
// Depends on pfru_pkg and the core; a frame-table predictor checks every result item.
module tb_page_frame_replacement_unit_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pfru_pkg::*;

  localparam int FRAMES       = 8;
  localparam int PAGE_W       = 16;
  localparam int FRAME_W      = 3;
  localparam int LIMIT_CYCLES = 300000;
  localparam int SETTLE       = 4;
  localparam int RAND_PHASES  = 10;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [FAULT_W-1:0] faults;
  } ref_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PAGE_W-1:0] in_page = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [FRAME_W-1:0] out_frame;
  logic out_evicted_valid;
  logic [PAGE_W-1:0] out_evicted_page;
  logic [FAULT_W-1:0] out_fault_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  page_frame_replacement_unit_core #(
    .FRAMES(FRAMES),
    .PAGE_BITS(PAGE_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_page(in_page),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_hit(out_hit),
    .out_frame(out_frame),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page(out_evicted_page),
    .out_fault_count(out_fault_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predicted frame table and counters
  logic [PAGE_W-1:0]  tbl_page   [FRAMES];
  logic               tbl_valid  [FRAMES];
  logic [31:0]        tbl_used   [FRAMES];
  logic [31:0]        tbl_loaded [FRAMES];
  logic [31:0]        step_cnt = '0;
  logic [FAULT_W-1:0] fault_cnt = '0;
  logic [COUNT_W-1:0] frame_count_reg = FRAME_COUNT_RESET;
  policy_t            policy_reg = POLICY_FIFO;

  logic [PAGE_W-1:0] page_q[$];
  ref_result_t       result_q[$];
  int issued_cnt = 0;
  int accepted_cnt = 0;
  int checked_cnt = 0;
  int hit_cnt = 0;
  int evict_cnt = 0;
  int cfg_cnt = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit gaps_on = 1'b1;

  initial begin
    for (int f = 0; f < FRAMES; f++) begin
      tbl_valid[f] = 1'b0;
    end
  end

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Hold lengths: mostly none, some short, a few long
  function automatic int pick_hold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Look the page up, update the frame table, return the expected result item
  function automatic ref_result_t lookup_page(input logic [PAGE_W-1:0] pg);
    ref_result_t r;
    int n;
    int match;
    int empty;
    int victim;
    logic [31:0] a;
    logic [31:0] b;
    r = '0;
    n = (frame_count_reg == 0) ? 1 : ((frame_count_reg > FRAMES) ? FRAMES : frame_count_reg);
    match = -1;
    empty = -1;
    for (int f = 0; f < n; f++) begin
      if (tbl_valid[f]) begin
        if (match < 0 && tbl_page[f] == pg) match = f;
      end else if (empty < 0) begin
        empty = f;
      end
    end
    if (match >= 0) begin
      r.hit = 1'b1;
      r.frame = match[FRAME_W-1:0];
      tbl_used[match] = step_cnt;
    end else begin
      fault_cnt = fault_cnt + 1;
      if (empty >= 0) begin
        victim = empty;
      end else begin
        victim = 0;
        for (int f = 1; f < n; f++) begin
          a = (policy_reg == POLICY_LRU) ? tbl_used[f] : tbl_loaded[f];
          b = (policy_reg == POLICY_LRU) ? tbl_used[victim] : tbl_loaded[victim];
          if (a < b) victim = f;
        end
        r.ev_valid = 1'b1;
        r.ev_page = tbl_page[victim];
      end
      r.frame = victim[FRAME_W-1:0];
      tbl_page[victim] = pg;
      tbl_valid[victim] = 1'b1;
      tbl_loaded[victim] = step_cnt;
      tbl_used[victim] = step_cnt;
    end
    r.faults = fault_cnt;
    step_cnt = step_cnt + 1;
    return r;
  endfunction

  // Input driver: take items from the page queue, with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        result_q.insert(result_q.size(), lookup_page(in_page));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (page_q.size() > 0) begin
          in_page <= page_q.pop_front();
          in_valid <= 1'b1;
          gap_left = gaps_on ? pick_hold() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Result monitor: compare each accepted item, drive random stall
  always @(posedge clk) begin
    ref_result_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: result item with nothing expected, frame %0d", $time, out_frame);
          err_cnt++;
        end else begin
          e = result_q.pop_front();
          check_field("hit", 32'(e.hit), 32'(out_hit));
          check_field("frame", 32'(e.frame), 32'(out_frame));
          check_field("evicted_valid", 32'(e.ev_valid), 32'(out_evicted_valid));
          check_field("evicted_page", 32'(e.ev_page), 32'(out_evicted_page));
          check_field("fault_count", e.faults, out_fault_count);
          hit_cnt += e.hit;
          evict_cnt += e.ev_valid;
          checked_cnt++;
        end
      end
      if (stall_left == 0 && gaps_on) stall_left = pick_hold();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Write one register; call and return at a rising edge
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FRAME_COUNT: frame_count_reg = data;
      REG_POLICY:      policy_reg = policy_t'(data[0]);
      default: ;
    endcase
    cfg_cnt++;
  endtask

  task automatic cfg_done();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_page(input logic [PAGE_W-1:0] pg);
    page_q.insert(page_q.size(), pg);
    issued_cnt++;
  endtask

  // Wait until every item has been taken and every result checked
  task automatic wait_idle();
    while (accepted_cnt != issued_cnt || checked_cnt != accepted_cnt) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Watchdog
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d of %0d results checked",
             cycle_cnt, checked_cnt, issued_cnt);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [PAGE_W-1:0] pool[16];
    int pool_n;
    int n_items;
    int r;
    logic [COUNT_W-1:0] cnt_val;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: fill all eight frames, hit once, then force a FIFO eviction
    queue_page(16'h0000);
    queue_page(16'hFFFF);
    queue_page(16'h5555);
    queue_page(16'hAAAA);
    queue_page(16'h0001);
    queue_page(16'h0002);
    queue_page(16'h0004);
    queue_page(16'h0008);
    queue_page(16'hFFFF);
    queue_page(16'h8000);
    wait_idle();

    // Two frames under LRU; unlisted register indexes must be ignored.
    // Page 8 sits beyond the count, so it misses and gets a second copy.
    cfg_write(REG_FRAME_COUNT, 4'd2);
    cfg_write(REG_POLICY, 4'd1);
    cfg_write(2'd2, 4'hF);
    cfg_write(2'd3, 4'hF);
    cfg_done();
    queue_page(16'h1234);
    queue_page(16'h8000);
    queue_page(16'h4321);
    queue_page(16'h0008);
    wait_idle();

    // Count above the frame total acts as all frames; duplicate hits the lowest frame
    cfg_write(REG_FRAME_COUNT, 4'd15);
    cfg_done();
    queue_page(16'h0008);
    queue_page(16'h0004);
    wait_idle();

    // Count of zero acts as one frame, FIFO
    cfg_write(REG_FRAME_COUNT, 4'd0);
    cfg_write(REG_POLICY, 4'd0);
    cfg_done();
    queue_page(16'h0007);
    queue_page(16'h0007);
    queue_page(16'h0009);
    wait_idle();

    // Random phases: working-set references with some noise
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: cnt_val = 4'd1;
        1: cnt_val = 4'd8;
        2: cnt_val = 4'd0;
        3: cnt_val = 4'd15;
        default: cnt_val = COUNT_W'($urandom_range(0, 15));
      endcase
      cfg_write(REG_FRAME_COUNT, cnt_val);
      cfg_write(REG_POLICY, CFG_DATA_W'($urandom_range(0, 15)));
      if (p % 3 == 1) begin
        cfg_write(CFG_IDX_W'($urandom_range(2, 3)), CFG_DATA_W'($urandom_range(0, 15)));
      end
      cfg_done();
      gaps_on = (p % 4 != 2);
      pool_n = $urandom_range(2, 12);
      for (int i = 0; i < pool_n; i++) pool[i] = PAGE_W'($urandom_range(0, 65535));
      n_items = $urandom_range(100, 150);
      for (int k = 0; k < n_items; k++) begin
        r = $urandom_range(0, 99);
        if (r < 78) queue_page(pool[$urandom_range(0, pool_n - 1)]);
        else if (r < 96) queue_page(PAGE_W'($urandom_range(0, 65535)));
        else queue_page($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (result_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, result_q.size());
      err_cnt++;
    end
    $display("covered %0d page references (%0d hits, %0d evictions) over %0d register writes",
             checked_cnt, hit_cnt, evict_cnt, cfg_cnt);
    $display("frame counts 0..15 and both policies, %0d mismatches", err_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
